[rtl/core/iodcs_pkg.sv]
// package for the debounce and contactor supervisor block
// types, register codes, reset values and counter step functions
// no dependencies
`default_nettype none

package iodcs_pkg;

  localparam int COUNT_WIDTH   = 4;
  localparam int CFG_WIDTH     = 4;
  localparam int CHECK_WIDTH   = 4;
  localparam int NUM_DEBOUNCED = 6;
  localparam int NUM_INPUTS    = 8;
  localparam int CFG_IDX_WIDTH = 2;
  localparam int CNT_EXT_WIDTH = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  // raw level bit 2 is the only active-high one
  localparam logic [NUM_DEBOUNCED-1:0] ACTIVE_HIGH_MASK = 6'b000100;

  localparam logic [CFG_IDX_WIDTH-1:0] REG_DEBOUNCE_LIMIT     = 2'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_FILTER_CHECK_TICKS = 2'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_OUTPUT_CHECK_TICKS = 2'd2;

  localparam logic [CFG_WIDTH-1:0] DEBOUNCE_LIMIT_RST     = 4'd3;
  localparam logic [CFG_WIDTH-1:0] FILTER_CHECK_TICKS_RST = 4'd6;
  localparam logic [CFG_WIDTH-1:0] OUTPUT_CHECK_TICKS_RST = 4'd10;

  typedef struct packed {
    logic [NUM_INPUTS-1:0] raw_levels;
    logic                  filter_close_cmd;
    logic                  output_close_cmd;
  } in_item_t;

  typedef struct packed {
    logic [NUM_INPUTS-1:0] input_flags;
    logic                  emergency_clear;
    logic                  filter_fault;
    logic                  output_fault;
  } out_item_t;

  typedef struct packed {
    logic [COUNT_WIDTH-1:0] count;
    logic                   top_hit;
    logic                   bottom_hit;
  } db_step_t;

  typedef struct packed {
    logic [CHECK_WIDTH-1:0] count;
    logic                   top_hit;
    logic                   bottom_hit;
  } chk_step_t;

  // saturating up/down step of a debounce counter
  function automatic db_step_t db_step(input logic [COUNT_WIDTH-1:0] cnt,
                                       input logic up,
                                       input logic [COUNT_WIDTH-1:0] top);
    db_step_t          r;
    logic [COUNT_WIDTH:0] n;
    r = '0;
    n = {1'b0, cnt} + {{COUNT_WIDTH{1'b0}}, 1'b1};
    if (up) begin
      if (n >= {1'b0, top}) begin
        r.count   = top;
        r.top_hit = 1'b1;
      end else begin
        r.count = n[COUNT_WIDTH-1:0];
      end
    end else if (cnt <= COUNT_WIDTH'(1)) begin
      r.count      = '0;
      r.bottom_hit = 1'b1;
    end else begin
      r.count = cnt - COUNT_WIDTH'(1);
    end
    return r;
  endfunction

  // saturating up/down step of a supervisor check counter
  function automatic chk_step_t chk_step(input logic [CHECK_WIDTH-1:0] cnt,
                                         input logic up,
                                         input logic [CHECK_WIDTH-1:0] top);
    chk_step_t            r;
    logic [CHECK_WIDTH:0] n;
    r = '0;
    n = {1'b0, cnt} + {{CHECK_WIDTH{1'b0}}, 1'b1};
    if (up) begin
      if (n >= {1'b0, top}) begin
        r.count   = top;
        r.top_hit = 1'b1;
      end else begin
        r.count = n[CHECK_WIDTH-1:0];
      end
    end else if (cnt <= CHECK_WIDTH'(1)) begin
      r.count      = '0;
      r.bottom_hit = 1'b1;
    end else begin
      r.count = cnt - CHECK_WIDTH'(1);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/core/io_debounce_contactor_supervisor_unit.sv]
// top level of the input debounce and contactor feedback supervisor
// depends on iodcs_pkg for item types, register codes and counter steps
//
// usage:
//   one input transfer is one sampling tick: eight raw pin levels plus the
//   filter and output contactor commands. every tick yields exactly one
//   result transfer: debounced flags, emergency clear and two sticky faults.
//   the result is registered and valid in the cycle after the input transfer;
//   throughput is one tick per clock, set by the single result register, which
//   is loaded whenever it is empty or being taken in the same cycle.
//   in_stall is high only while a result is held and out_stall is high, so
//   a stalled receiver holds the result steady and backs up the input side.
//   config writes (cfg_wr_en, cfg_index, cfg_data) take effect the next
//   cycle; unknown indexes are ignored.
//   reset clears all counters, flags and faults, drops out_valid and loads
//   the register reset values 3, 6 and 10. faults clear only on reset.
`default_nettype none

module io_debounce_contactor_supervisor_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output      logic                          in_stall,
  input  wire iodcs_pkg::in_item_t           in_data,
  output      logic                          out_valid,
  input  wire logic                          out_stall,
  output      iodcs_pkg::out_item_t          out_data,
  input  wire logic                          cfg_wr_en,
  input  wire logic [iodcs_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
  input  wire logic [iodcs_pkg::CFG_WIDTH-1:0]     cfg_data
);

  import iodcs_pkg::*;

  logic [CFG_WIDTH-1:0]     debounce_limit;
  logic [CFG_WIDTH-1:0]     filter_check_ticks;
  logic [CFG_WIDTH-1:0]     output_check_ticks;

  logic [COUNT_WIDTH-1:0]   debounce_counts [NUM_DEBOUNCED];
  logic [COUNT_WIDTH-1:0]   debounce_counts_next [NUM_DEBOUNCED];
  logic [NUM_DEBOUNCED-1:0] debounced_bits;
  logic [NUM_DEBOUNCED-1:0] debounced_bits_next;
  logic [CHECK_WIDTH-1:0]   filter_check_count;
  logic [CHECK_WIDTH-1:0]   output_check_count;
  logic [1:0]               fault_bits;
  logic [1:0]               fault_bits_next;

  logic                     accept;
  logic [CNT_EXT_WIDTH-1:0] limit_ext;
  logic [COUNT_WIDTH-1:0]   limit;
  logic [NUM_DEBOUNCED-1:0] active;
  db_step_t                 db_res [NUM_DEBOUNCED];
  chk_step_t                filt_res;
  chk_step_t                outp_res;
  out_item_t                result;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_limit     <= DEBOUNCE_LIMIT_RST;
      filter_check_ticks <= FILTER_CHECK_TICKS_RST;
      output_check_ticks <= OUTPUT_CHECK_TICKS_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_DEBOUNCE_LIMIT:     debounce_limit     <= cfg_data;
        REG_FILTER_CHECK_TICKS: filter_check_ticks <= cfg_data;
        REG_OUTPUT_CHECK_TICKS: output_check_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  // limit saturated to the counter range
  always_comb begin
    limit_ext = CNT_EXT_WIDTH'(debounce_limit);
    if (limit_ext > CNT_EXT_WIDTH'(COUNT_MAX)) begin
      limit = COUNT_MAX;
    end else begin
      limit = COUNT_WIDTH'(limit_ext);
    end
  end

  assign active = in_data.raw_levels[NUM_DEBOUNCED-1:0] ^ ~ACTIVE_HIGH_MASK;

  always_comb begin
    for (int k = 0; k < NUM_DEBOUNCED; k++) begin
      db_res[k]               = db_step(debounce_counts[k], active[k], limit);
      debounce_counts_next[k] = db_res[k].count;
      if (db_res[k].top_hit) begin
        debounced_bits_next[k] = 1'b1;
      end else if (db_res[k].bottom_hit) begin
        debounced_bits_next[k] = 1'b0;
      end else begin
        debounced_bits_next[k] = debounced_bits[k];
      end
    end
  end

  // supervisors use the aux flags updated this tick
  always_comb begin
    filt_res = chk_step(filter_check_count, !in_data.filter_close_cmd,
                        filter_check_ticks);
    outp_res = chk_step(output_check_count, !in_data.output_close_cmd,
                        output_check_ticks);
    fault_bits_next = fault_bits;
    if ((filt_res.top_hit && debounced_bits_next[4]) ||
        (filt_res.bottom_hit && !debounced_bits_next[4])) begin
      fault_bits_next[0] = 1'b1;
    end
    if ((outp_res.top_hit && debounced_bits_next[5]) ||
        (outp_res.bottom_hit && !debounced_bits_next[5])) begin
      fault_bits_next[1] = 1'b1;
    end
  end

  always_comb begin
    result.input_flags     = {~in_data.raw_levels[NUM_INPUTS-1:NUM_DEBOUNCED],
                              debounced_bits_next};
    result.emergency_clear = !debounced_bits_next[0];
    result.filter_fault    = fault_bits_next[0];
    result.output_fault    = fault_bits_next[1];
  end

  // tick state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_DEBOUNCED; k++) begin
        debounce_counts[k] <= '0;
      end
      debounced_bits     <= '0;
      filter_check_count <= '0;
      output_check_count <= '0;
      fault_bits         <= '0;
    end else if (accept) begin
      for (int k = 0; k < NUM_DEBOUNCED; k++) begin
        debounce_counts[k] <= debounce_counts_next[k];
      end
      debounced_bits     <= debounced_bits_next;
      filter_check_count <= filt_res.count;
      output_check_count <= outp_res.count;
      fault_bits         <= fault_bits_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= result;
    end
  end

  a_fault_sticky: assert property (@(posedge clk) disable iff (rst)
    (fault_bits[0] |=> fault_bits[0]) and (fault_bits[1] |=> fault_bits[1]))
    else $error("supervisor fault cleared without reset");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with result register empty");

  a_transfer_gives_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> out_valid)
    else $error("accepted tick produced no result");

  a_estop_matches_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.emergency_clear == !out_data.input_flags[0]))
    else $error("emergency clear disagrees with flag 1");

  a_fault_matches_state: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=>
      (out_data.filter_fault == fault_bits[0]) &&
      (out_data.output_fault == fault_bits[1]))
    else $error("reported faults differ from fault state");

endmodule

`default_nettype wire

[test/io_debounce_contactor_supervisor_unit_tb.sv]
// testbench for io_debounce_contactor_supervisor_unit: drives sampling ticks and checks
// every result against a local predictor of the debounce and supervisor logic
// depends on iodcs_pkg and the unit under test
`timescale 1ns / 100ps

module io_debounce_contactor_supervisor_unit_tb;
  import iodcs_pkg::*;

  localparam int HOLD_CYCLES = 80;
  localparam int TIMEOUT_NS  = 5_000_000;
  localparam int MAX_REPORTS = 10;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_UNUSED = 2'd3;
  localparam int FILTER = 0;
  localparam int OUTPUT = 1;

  typedef enum logic [1:0] {HIT_NONE, HIT_TOP, HIT_BOTTOM} sat_hit_e;

  typedef struct packed {
    logic [COUNT_WIDTH-1:0] count;
    sat_hit_e               hit;
  } sat_res_t;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_stall;
  in_item_t in_data;
  logic out_valid;
  logic out_stall;
  out_item_t out_data;
  logic cfg_wr_en;
  logic [CFG_IDX_WIDTH-1:0] cfg_index;
  logic [CFG_WIDTH-1:0] cfg_data;

  // predicted block state
  logic [COUNT_WIDTH-1:0] db_count [NUM_DEBOUNCED];
  logic [NUM_DEBOUNCED-1:0] db_flags;
  logic [COUNT_WIDTH-1:0] fchk_count;
  logic [COUNT_WIDTH-1:0] ochk_count;
  logic [1:0] fault_r;
  logic [CFG_WIDTH-1:0] lim_r;
  logic [CFG_WIDTH-1:0] fticks_r;
  logic [CFG_WIDTH-1:0] oticks_r;

  out_item_t pending_status_q[$];
  int mismatch_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_req = 1'b0;

  // stimulus state of the contactor sequences
  bit ctr_cmd [2];
  bit ctr_aux [2];
  int ctr_hold [2];
  int ctr_lag [2];
  logic [7:0] wander = 8'h00;

  io_debounce_contactor_supervisor_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic sat_res_t sat_step(input logic [COUNT_WIDTH-1:0] cnt, input logic up,
                                        input logic [COUNT_WIDTH-1:0] top);
    sat_res_t r;
    logic [COUNT_WIDTH:0] nxt;
    nxt = {1'b0, cnt} + 1'b1;
    r.count = cnt;
    r.hit = HIT_NONE;
    if (up) begin
      if (nxt >= {1'b0, top}) begin
        r.count = top;
        r.hit = HIT_TOP;
      end else begin
        r.count = nxt[COUNT_WIDTH-1:0];
      end
    end else if (cnt <= 1) begin
      r.count = '0;
      r.hit = HIT_BOTTOM;
    end else begin
      r.count = cnt - 1'b1;
    end
    return r;
  endfunction

  // one sampling tick: update predicted state, return the qualified status
  function automatic out_item_t qualify_tick(input in_item_t item);
    out_item_t res;
    sat_res_t r;
    logic active;
    int k;
    for (k = 0; k < NUM_DEBOUNCED; k++) begin
      active = ACTIVE_HIGH_MASK[k] ? item.raw_levels[k] : ~item.raw_levels[k];
      r = sat_step(db_count[k], active, lim_r);
      db_count[k] = r.count;
      if (r.hit == HIT_TOP) db_flags[k] = 1'b1;
      else if (r.hit == HIT_BOTTOM) db_flags[k] = 1'b0;
    end
    r = sat_step(fchk_count, ~item.filter_close_cmd, fticks_r);
    fchk_count = r.count;
    if ((r.hit == HIT_TOP && db_flags[4]) || (r.hit == HIT_BOTTOM && !db_flags[4]))
      fault_r[0] = 1'b1;
    r = sat_step(ochk_count, ~item.output_close_cmd, oticks_r);
    ochk_count = r.count;
    if ((r.hit == HIT_TOP && db_flags[5]) || (r.hit == HIT_BOTTOM && !db_flags[5]))
      fault_r[1] = 1'b1;
    res.input_flags = {~item.raw_levels[7:6], db_flags};
    res.emergency_clear = ~db_flags[0];
    res.filter_fault = fault_r[0];
    res.output_fault = fault_r[1];
    return res;
  endfunction

  function automatic in_item_t make_item(input logic [7:0] raw, input logic fc,
                                         input logic oc);
    in_item_t item;
    item.raw_levels = raw;
    item.filter_close_cmd = fc;
    item.output_close_cmd = oc;
    return item;
  endfunction

  // slowly wandering levels so that debounce counters actually saturate
  function automatic logic [7:0] next_wander(input logic [7:0] cur);
    logic [7:0] nxt;
    int b;
    nxt = cur;
    for (b = 0; b < 8; b++)
      if ($urandom_range(99) < 20) nxt[b] = ~nxt[b];
    return nxt;
  endfunction

  task automatic note_mismatch(input string what, input int exp_v, input int act_v);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("mismatch %s: expected %0h, got %0h at %0t", what, exp_v, act_v, $time);
  endtask

  task automatic send_tick(input in_item_t item);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_status_q.push_back(qualify_tick(item));
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_status_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic configure(input logic [CFG_IDX_WIDTH-1:0] idx,
                           input logic [CFG_WIDTH-1:0] val);
    wait_idle();
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_DEBOUNCE_LIMIT:     lim_r = val;
      REG_FILTER_CHECK_TICKS: fticks_r = val;
      REG_OUTPUT_CHECK_TICKS: oticks_r = val;
      default: ;
    endcase
  endtask

  task automatic set_thresholds(input int lim, input int fchk, input int ochk);
    configure(REG_DEBOUNCE_LIMIT, CFG_WIDTH'(lim));
    configure(REG_FILTER_CHECK_TICKS, CFG_WIDTH'(fchk));
    configure(REG_OUTPUT_CHECK_TICKS, CFG_WIDTH'(ochk));
  endtask

  // aux feedback follows each command after a short lag; freeze holds the commands
  task automatic drive_wellformed(input int n, input bit freeze);
    int hold_min;
    int max_lag;
    int ft;
    int ot;
    int lm;
    int c;
    in_item_t item;
    ft = (fticks_r == 0) ? 1 : fticks_r;
    ot = (oticks_r == 0) ? 1 : oticks_r;
    lm = (lim_r == 0) ? 1 : lim_r;
    hold_min = ((ft > ot) ? ft : ot) + 1;
    max_lag = ((ft < ot) ? ft : ot) - lm;
    if (max_lag < 0) max_lag = 0;
    if (max_lag > 2) max_lag = 2;
    repeat (n) begin
      for (c = 0; c < 2; c++) begin
        if (freeze) begin
          ctr_aux[c] = ctr_cmd[c];
        end else begin
          if (ctr_hold[c] == 0) begin
            ctr_cmd[c] = ~ctr_cmd[c];
            ctr_hold[c] = hold_min + $urandom_range(12);
            ctr_lag[c] = $urandom_range(max_lag);
          end else begin
            ctr_hold[c]--;
          end
          if (ctr_lag[c] == 0) ctr_aux[c] = ctr_cmd[c];
          else ctr_lag[c]--;
        end
      end
      wander = next_wander(wander);
      item = make_item(wander, ctr_cmd[FILTER], ctr_cmd[OUTPUT]);
      item.raw_levels[4] = ~ctr_aux[FILTER];
      item.raw_levels[5] = ~ctr_aux[OUTPUT];
      send_tick(item);
    end
  endtask

  task automatic run_contactor_phase(input int lim, input int fchk, input int ochk);
    set_thresholds(lim, fchk, ochk);
    drive_wellformed(95, 1'b0);
    drive_wellformed(17, 1'b1);
  endtask

  task automatic test_directed_levels();
    repeat (3) send_tick(make_item(8'h00, 1'b0, 1'b0));
    repeat (3) send_tick(make_item(8'hFF, 1'b0, 1'b0));
    repeat (10) send_tick(make_item(8'h00, 1'b1, 1'b1));
    repeat (4) send_tick(make_item(8'hFF, 1'b0, 1'b0));
    repeat (3) begin
      send_tick(make_item(8'h75, 1'b0, 1'b0));
      send_tick(make_item(8'hBA, 1'b0, 1'b0));
    end
  endtask

  task automatic test_contactor_cycles();
    send_idle_pct = 9;
    recv_idle_pct = 64;
    run_contactor_phase(3, 6, 10);
    configure(REG_UNUSED, 4'hF);
    run_contactor_phase(1, 15, 15);
    run_contactor_phase(15, 15, 15);
    run_contactor_phase(0, 0, 0);
    send_idle_pct = 64;
    recv_idle_pct = 9;
    run_contactor_phase(2, 3, 4);
    run_contactor_phase(0, 1, 15);
    run_contactor_phase(5, 9, 12);
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req = 1'b1;
    drive_wellformed(24, 1'b0);
    drive_wellformed(17, 1'b1);
  endtask

  task automatic test_filter_fault();
    set_thresholds(2, 3, 4);
    ctr_cmd[FILTER] = 1'b0;
    ctr_cmd[OUTPUT] = 1'b0;
    drive_wellformed(8, 1'b1);
    // filter aux closes while the contactor is commanded open
    repeat (6) begin
      wander = next_wander(wander);
      send_tick(make_item((wander & 8'hCF) | 8'h20, 1'b0, 1'b0));
    end
  endtask

  task automatic test_output_fault();
    // output commanded closed, aux never follows
    repeat (8) begin
      wander = next_wander(wander);
      send_tick(make_item(wander | 8'h30, 1'b0, 1'b1));
    end
  endtask

  task automatic test_random_noise();
    int p;
    logic fc;
    logic oc;
    fc = 1'b0;
    oc = 1'b0;
    for (p = 0; p < 5; p++) begin
      case (p)
        0: set_thresholds(15, 0, 15);
        1: set_thresholds(0, 15, 0);
        default: set_thresholds($urandom_range(15), $urandom_range(15), $urandom_range(15));
      endcase
      if (p == 3) configure(REG_UNUSED, CFG_WIDTH'($urandom_range(15)));
      repeat (50) begin
        if ($urandom_range(99) < 10) fc = ~fc;
        if ($urandom_range(99) < 10) oc = ~oc;
        wander = next_wander(wander);
        if ($urandom_range(1)) send_tick(make_item(wander, fc, oc));
        else send_tick(make_item(8'($urandom_range(255)), 1'($urandom_range(1)),
                                 1'($urandom_range(1))));
      end
    end
  endtask

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_status_q.size() == 0) begin
        note_mismatch("unexpected transfer", 0, out_data);
      end else begin
        want = pending_status_q.pop_front();
        if (out_data.input_flags !== want.input_flags)
          note_mismatch("input_flags", want.input_flags, out_data.input_flags);
        if (out_data.emergency_clear !== want.emergency_clear)
          note_mismatch("emergency_clear", want.emergency_clear, out_data.emergency_clear);
        if (out_data.filter_fault !== want.filter_fault)
          note_mismatch("filter_fault", want.filter_fault, out_data.filter_fault);
        if (out_data.output_fault !== want.output_fault)
          note_mismatch("output_fault", want.output_fault, out_data.output_fault);
      end
    end
  end

  initial begin : receiver
    int n;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        for (n = 0; n < HOLD_CYCLES; n++) @(negedge clk);
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : main
    int k;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    for (k = 0; k < NUM_DEBOUNCED; k++) db_count[k] = '0;
    db_flags = '0;
    fchk_count = '0;
    ochk_count = '0;
    fault_r = '0;
    lim_r = DEBOUNCE_LIMIT_RST;
    fticks_r = FILTER_CHECK_TICKS_RST;
    oticks_r = OUTPUT_CHECK_TICKS_RST;
    for (k = 0; k < 2; k++) begin
      ctr_cmd[k] = 1'b0;
      ctr_aux[k] = 1'b0;
      ctr_hold[k] = 0;
      ctr_lag[k] = 0;
    end
    send_idle_pct = 9;
    recv_idle_pct = 64;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    test_directed_levels();
    test_contactor_cycles();
    test_backpressure();
    test_filter_fault();
    test_output_fault();
    test_random_noise();

    wait_idle();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0 && pending_status_q.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
